FILE: src/url_percent_decoder_unit_assert.svh
// Assertion macros shared by the URL percent decoder checkers.
// No dependencies; include by bare file name.
`ifndef URL_PERCENT_DECODER_UNIT_ASSERT_SVH
`define URL_PERCENT_DECODER_UNIT_ASSERT_SVH

// Check a property on every rising edge while reset is released.
`define UPD_ASSERT_RUN(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("url_percent_decoder_unit: assertion failed");

// Check a property on every rising edge, reset included.
`define UPD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("url_percent_decoder_unit: assertion failed");

`endif

FILE: src/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies.
package upd_pkg;

  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_LA      = 8'h61;
  localparam logic [7:0] CHR_LF      = 8'h66;
  localparam logic [7:0] CHR_UA      = 8'h41;
  localparam logic [7:0] CHR_UF      = 8'h46;
  localparam logic [7:0] HEX_TEN     = 8'd10;

  localparam int unsigned MAX_OUT = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } upd_phase_t;

  // One decoded command: up to three bytes to emit, in order.
  typedef struct packed {
    logic [1:0]              cnt;
    logic                    last;
    logic [MAX_OUT-1:0][7:0] data;
  } upd_cmd_t;

  // Queue head status toward the back end: valid flag and head command.
  typedef struct packed {
    logic     valid;
    upd_cmd_t cmd;
  } upd_head_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CHR_ZERO && c <= CHR_NINE) || (c >= CHR_LA && c <= CHR_LF) ||
           (c >= CHR_UA && c <= CHR_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHR_ZERO && c <= CHR_NINE) v = c - CHR_ZERO;
    else if (c >= CHR_LA && c <= CHR_LF) v = c - CHR_LA + HEX_TEN;
    else if (c >= CHR_UA && c <= CHR_UF) v = c - CHR_UA + HEX_TEN;
    return v[3:0];
  endfunction

endpackage

FILE: src/upd_front.sv
// Front end: accepts encoded bytes, tracks the escape phase, builds commands.
// Depends on upd_pkg.
module upd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            cmd_push,
  output upd_pkg::upd_cmd_t cmd
);
  import upd_pkg::*;

  upd_phase_t phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       b_hex;
  logic       go_pct;
  logic       idle_emit;
  logic [7:0] idle_chr;
  logic       use_idle;
  logic [1:0] pre;

  assign b_hex  = is_hex(in_byte);
  assign go_pct = (in_byte == CHR_PERCENT) && !in_last;

  // Plain decode of one byte from the idle phase.
  always_comb begin
    idle_emit = !go_pct;
    if (in_byte == CHR_PLUS) idle_chr = CHR_SPACE;
    else idle_chr = in_byte;
  end

  // Next phase and held digit.
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (fire) begin
      unique case (phase_r)
        PH_PCT: begin
          if (b_hex && !in_last) begin
            phase_nxt = PH_DIG;
            held_nxt  = in_byte;
          end else begin
            phase_nxt = go_pct ? PH_PCT : PH_IDLE;
          end
        end
        PH_DIG: begin
          if (b_hex) phase_nxt = PH_IDLE;
          else phase_nxt = go_pct ? PH_PCT : PH_IDLE;
        end
        default: phase_nxt = go_pct ? PH_PCT : PH_IDLE;
      endcase
    end
  end

  // Command built from the current phase and byte.
  always_comb begin
    cmd      = '0;
    cmd.last = in_last;
    use_idle = 1'b1;
    pre      = 2'd0;
    unique case (phase_r)
      PH_PCT: begin
        if (b_hex && !in_last) begin
          use_idle = 1'b0;
        end else begin
          cmd.data[0] = CHR_PERCENT;
          pre         = 2'd1;
        end
      end
      PH_DIG: begin
        if (b_hex) begin
          use_idle    = 1'b0;
          cmd.data[0] = {hex_val(held_r), hex_val(in_byte)};
          cmd.cnt     = 2'd1;
        end else begin
          cmd.data[0] = CHR_PERCENT;
          cmd.data[1] = held_r;
          pre         = 2'd2;
        end
      end
      default: pre = 2'd0;
    endcase
    if (use_idle) begin
      unique case (pre)
        2'd1:    cmd.data[1] = idle_chr;
        2'd2:    cmd.data[2] = idle_chr;
        default: cmd.data[0] = idle_chr;
      endcase
      cmd.cnt = pre + {1'b0, idle_emit};
    end
  end

  assign cmd_push = fire && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: src/upd_queue.sv
// Two-entry command queue between front and back end.
// Depends on upd_pkg.
module upd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::upd_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output upd_pkg::upd_head_t head
);
  import upd_pkg::*;

  upd_cmd_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/upd_back.sv
// Back end: walks the bytes of the head command out one per transfer.
// Depends on upd_pkg.
module upd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  upd_pkg::upd_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import upd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       at_end;

  assign at_end    = (idx_r == head.cmd.cnt - 2'd1);
  assign out_valid = head.valid;
  assign out_last  = head.cmd.last && at_end;
  assign pop       = out_valid && out_ready && at_end;

  always_comb begin
    unique case (idx_r)
      2'd1:    out_byte = head.cmd.data[1];
      2'd2:    out_byte = head.cmd.data[2];
      default: out_byte = head.cmd.data[0];
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else idx_r <= idx_nxt;
  end

endmodule

FILE: src/url_percent_decoder_unit.sv
// Top level of the streaming URL percent decoder.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
//   channel | ports                           | direction
//   --------+---------------------------------+----------
//   input   | in_valid in_ready in_byte in_last    | in
//   result  | out_valid out_ready out_byte out_last | out
//
// An input byte is taken in the cycle it arrives unless the command queue
// holds two commands. Bytes that yield at most one result sustain one item
// per cycle when out_ready is high; an item releasing k bytes (up to three)
// keeps the back end busy for k transfers; its drain rate sets throughput.
// Reset (rst_n low, synchronous) clears the escape phase, held digit, queue
// pointers and serializer index; no clearing pass is needed.
// A stall on the result side fills the queue and then drops in_ready.
module url_percent_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import upd_pkg::*;

  logic      fire;
  logic      cmd_push;
  upd_cmd_t  cmd;
  logic      q_full;
  logic      pop;
  upd_head_t head;

  // Accept whenever the queue has room; zero-result bytes only advance state.
  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // Decouple classification from emission so each side stalls on its own.
  upd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: src/upd_checker.sv
// Port-level checks for url_percent_decoder_unit, bound to the top level.
// Depends on url_percent_decoder_unit_assert.svh.
`include "url_percent_decoder_unit_assert.svh"

module upd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled result holds its payload.
  `UPD_ASSERT_RUN(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))

  // Nothing is offered in the cycle after reset.
  `UPD_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_valid)

  // Back-pressure on the input only when results are waiting.
  `UPD_ASSERT_RUN(a_ready_low_pending, clk, rst_n, !in_ready |-> out_valid)

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_byte   (in_byte),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

FILE: tb/testbench.sv
// Self-checking testbench for url_percent_decoder_unit: directed table, then random strings.
// Depends on upd_pkg (character constants, phase enum) and the decoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  // Decoded bytes caused by one input byte, first byte in data[0].
  typedef struct packed {
    logic [1:0]       cnt;
    logic             last;
    logic [2:0][7:0]  data;
  } decoded_t;

  // One encoded character to send; typed rows carry a hand-written answer.
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       typed;
    decoded_t   want;
  } enc_char_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } dec_char_t;

  typedef enum logic [1:0] {RX_FULL, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  enc_char_t  enc_q[$];
  dec_char_t  dec_q[$];

  upd_phase_t dec_phase = PH_IDLE;
  logic [7:0] dec_held  = 8'h00;

  int         errors     = 0;
  int         accepted   = 0;
  bit         took       = 1'b0;
  int         gap_left   = 0;
  int         burst_left = 1;
  bit         hold_off   = 1'b0;
  rx_mode_t   rx_mode    = RX_FULL;
  int         rx_left    = 0;
  logic [1:0] rx_tick    = 2'd0;

  url_percent_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic hex_char(input logic [7:0] c);
    return (c >= CHR_ZERO && c <= CHR_NINE) || (c >= CHR_LA && c <= CHR_LF) ||
           (c >= CHR_UA && c <= CHR_UF);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CHR_NINE) v = c - CHR_ZERO;
    else if (c >= CHR_LA) v = c - CHR_LA + 8'd10;
    else v = c - CHR_UA + 8'd10;
    return v[3:0];
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic add_out(inout decoded_t d, input logic [7:0] c);
    d.data[d.cnt] = c;
    d.cnt++;
  endtask

  // Decode a byte with no escape pending; a percent on the last byte stays literal.
  task automatic plain_char(inout decoded_t d, input logic [7:0] c, input logic l);
    if (c == CHR_PLUS) add_out(d, CHR_SPACE);
    else if (c == CHR_PERCENT && !l) dec_phase = PH_PCT;
    else add_out(d, c);
  endtask

  // Advance the escape state by one encoded byte and return what it releases.
  task automatic decode_step(input logic [7:0] c, input logic l, output decoded_t d);
    upd_phase_t ph;
    d = '0;
    ph = dec_phase;
    dec_phase = PH_IDLE;
    case (ph)
      PH_PCT: begin
        if (hex_char(c) && !l) begin
          dec_held = c;
          dec_phase = PH_DIG;
        end else begin
          add_out(d, CHR_PERCENT);
          plain_char(d, c, l);
        end
      end
      PH_DIG: begin
        if (hex_char(c)) begin
          add_out(d, {nibble_of(dec_held), nibble_of(c)});
        end else begin
          add_out(d, CHR_PERCENT);
          add_out(d, dec_held);
          plain_char(d, c, l);
        end
      end
      default: plain_char(d, c, l);
    endcase
    d.last = l && (d.cnt != 0);
  endtask

  task automatic add_row(input logic [7:0] c, input logic l, input logic typed, input int n,
                         input logic [7:0] e0, input logic [7:0] e1, input logic [7:0] e2);
    enc_char_t s;
    s.chr = c;
    s.last = l;
    s.typed = typed;
    s.want.cnt = n[1:0];
    s.want.last = l;
    s.want.data[0] = e0;
    s.want.data[1] = e1;
    s.want.data[2] = e2;
    enc_q.push_back(s);
  endtask

  function automatic logic [7:0] pick_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    c = 8'($urandom);
    while (hex_char(c)) c = 8'($urandom);
    return c;
  endfunction

  // Mostly well-formed strings with random content; some noise and cut-off escapes.
  task automatic build_random(input int target);
    int         made;
    int         len;
    logic [7:0] c;
    logic [7:0] str_q[$];
    made = 0;
    while (made < target) begin
      str_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          c = 8'($urandom);
          add_row(c, $urandom_range(0, 5) == 0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
          made++;
        end
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          case ($urandom_range(0, 11))
            0, 1, 2, 3: begin
              c = 8'($urandom);
              str_q.push_back(c);
            end
            4: str_q.push_back(CHR_PLUS);
            5, 6, 7: begin
              str_q.push_back(CHR_PERCENT);
              str_q.push_back(pick_hex());
              str_q.push_back(pick_hex());
            end
            8: begin
              str_q.push_back(CHR_PERCENT);
              str_q.push_back(pick_non_hex());
            end
            9: begin
              str_q.push_back(CHR_PERCENT);
              str_q.push_back(pick_hex());
              str_q.push_back(pick_non_hex());
            end
            10: str_q.push_back(CHR_PERCENT);
            default: str_q.push_back(pick_hex());
          endcase
        end
        // drop the tail now and then so an escape runs into the string's end
        if (str_q.size() > 1 && $urandom_range(0, 4) == 0) void'(str_q.pop_back());
        foreach (str_q[i]) begin
          add_row(str_q[i], i == str_q.size() - 1, 1'b0, 0, 8'h00, 8'h00, 8'h00);
          made++;
        end
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps; hold until transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      // hold the offered byte until it transfers
    end else begin
      took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (enc_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_byte  <= enc_q[0].chr;
        in_last  <= enc_q[0].last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: switch between stall patterns; drop ready entirely during the hold-off.
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_FULL:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= ($urandom_range(0, 1) == 0);
        RX_QUARTER: out_ready <= (rx_tick == 2'd0);
        default:    out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Long receiver hold-off while the sender keeps offering, to back up the queue.
  initial begin
    while (accepted < 90) @(negedge clk);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  // Predict on each input transfer, then check each output transfer.
  always @(posedge clk) begin : watch
    enc_char_t s;
    decoded_t  d;
    dec_char_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        s = enc_q.pop_front();
        took = 1'b1;
        accepted++;
        decode_step(s.chr, s.last, d);
        if (s.typed) d = s.want;
        for (int i = 0; i < d.cnt; i++) begin
          w.chr = d.data[i];
          w.last = d.last && (i == d.cnt - 1);
          dec_q.push_back(w);
        end
      end
      if (out_valid && out_ready) begin
        if (dec_q.size() == 0) begin
          note_error($sformatf("unexpected byte %h last %b", out_byte, out_last));
        end else begin
          w = dec_q.pop_front();
          if (out_byte !== w.chr)
            note_error($sformatf("out_byte expected %h actual %h", w.chr, out_byte));
          if (out_last !== w.last)
            note_error($sformatf("out_last expected %b actual %b (byte %h)",
                                 w.last, out_last, w.chr));
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    in_last   = 1'b0;
    out_ready = 1'b0;

    // extremes and plus
    add_row(8'h00, 1'b0, 1'b1, 1, 8'h00, 8'h00, 8'h00);
    add_row(8'hFF, 1'b0, 1'b1, 1, 8'hFF, 8'h00, 8'h00);
    add_row(CHR_PLUS, 1'b0, 1'b1, 1, CHR_SPACE, 8'h00, 8'h00);
    // full escape, upper and lower case digits
    add_row(CHR_PERCENT, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
    add_row("4", 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
    add_row("1", 1'b0, 1'b1, 1, "A", 8'h00, 8'h00);
    add_row(CHR_PERCENT, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
    add_row("f", 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
    add_row("F", 1'b1, 1'b1, 1, 8'hFF, 8'h00, 8'h00);
    // percent on the last byte stays literal
    add_row(CHR_PERCENT, 1'b1, 1'b1, 1, CHR_PERCENT, 8'h00, 8'h00);
    // percent then a hex digit that ends the string
    add_row(CHR_PERCENT, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
    add_row("4", 1'b1, 1'b1, 2, CHR_PERCENT, "4", 8'h00);
    // percent then non-hex
    add_row(CHR_PERCENT, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row("g", 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    // percent then percent, the second one opens a new escape
    add_row(CHR_PERCENT, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row(CHR_PERCENT, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row("2", 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row("0", 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    // non-hex after the first digit releases three bytes
    add_row(CHR_PERCENT, 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
    add_row("A", 1'b0, 1'b1, 0, 8'h00, 8'h00, 8'h00);
    add_row("z", 1'b1, 1'b1, 3, CHR_PERCENT, "A", "z");
    add_row(CHR_PERCENT, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row("9", 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row(CHR_PLUS, 1'b0, 1'b0, 0, 8'h00, 8'h00, 8'h00);
    add_row(CHR_PLUS, 1'b1, 1'b1, 1, CHR_SPACE, 8'h00, 8'h00);

    build_random(150);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (enc_q.size() != 0 || dec_q.size() != 0);
    repeat (20) @(negedge clk);

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
